>>> rtl/ggoa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the greedy grid owner assigner.
// No dependencies; every other rtl file but ggoa_if takes names from here by scope.
package ggoa_pkg;

   localparam int LOAD_W     = 62;
   localparam int COST_W     = 48;
   localparam int PEN_W      = 50;
   localparam int SCORE_W    = 77;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [LOAD_W-1:0] LOAD_MAX   = {LOAD_W{1'b1}};
   localparam logic [COST_W-1:0] COST_FLOOR = COST_W'(8);

   localparam int COST_CYCLES  = 4;
   localparam int DRAIN_CYCLES = 4;

   localparam logic [1:0] REG_GRID_ROWS       = 2'd0;
   localparam logic [1:0] REG_GRID_COLS       = 2'd1;
   localparam logic [1:0] REG_AFFINITY_WEIGHT = 2'd2;

   localparam logic FUNC_CLEAR = 1'b0;

   typedef enum logic [2:0] {
      ST_RESET_SWEEP,
      ST_IDLE,
      ST_COST,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_CLEAR_SWEEP,
      ST_CLEAR_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_valid;
      logic sweep;
      logic commit;
      logic emit;
      logic emit_zero;
      logic rows_multi;
   } cmd_type;

endpackage

>>> rtl/ggoa_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces, valid/ready handshake.
// Depends on nothing.
interface ggoa_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [9:0]  task_index;
   logic [9:0]  task_columns;
   logic [15:0] panel_height;
   logic [10:0] parent_index;

   modport source (output valid, func, task_index, task_columns, panel_height, parent_index,
                   input ready);
   modport sink   (input valid, func, task_index, task_columns, panel_height, parent_index,
                   output ready);
endinterface

interface ggoa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  chosen_row;
   logic [2:0]  chosen_col;
   logic [61:0] max_column_load;
   logic [61:0] max_row_load;
   logic [61:0] max_cell_load;

   modport source (output valid, chosen_row, chosen_col, max_column_load, max_row_load,
                   max_cell_load, input ready);
   modport sink   (input valid, chosen_row, chosen_col, max_column_load, max_row_load,
                   max_cell_load, output ready);
endinterface

>>> rtl/ggoa_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences cost, cell scan, drain, commit and clearing sweeps.
// Depends on ggoa_pkg; drives the datapath through ggoa_pkg::cmd_type.
module ggoa_ctrl #(
   parameter int MAX_TASKS     = 1024,
   parameter int MAX_GRID_ROWS = 8,
   parameter int MAX_GRID_COLS = 8,
   localparam int RW        = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1,
   localparam int CW        = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1,
   localparam int CELLS     = MAX_GRID_ROWS * MAX_GRID_COLS,
   localparam int SWEEP_LEN = (MAX_TASKS > CELLS) ? MAX_TASKS : CELLS,
   localparam int SW        = $clog2(SWEEP_LEN)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [3:0]          grid_rows,
   input  logic [3:0]          grid_cols,
   output ggoa_pkg::cmd_type   cmd,
   output logic [RW-1:0]       scan_row,
   output logic [CW-1:0]       scan_col,
   output logic [SW-1:0]       sweep_addr
);
   ggoa_pkg::state_type state_ff, state_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic [RW-1:0] row_ff, row_in, last_row;
   logic [CW-1:0] col_ff, col_in, last_col;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free, sweep_end, scan_end;

   always_comb begin
      if (grid_rows == 4'd0) begin
         last_row = '0;
      end else if (32'(grid_rows) > MAX_GRID_ROWS) begin
         last_row = RW'(MAX_GRID_ROWS - 1);
      end else begin
         last_row = RW'(grid_rows - 4'd1);
      end
      if (grid_cols == 4'd0) begin
         last_col = '0;
      end else if (32'(grid_cols) > MAX_GRID_COLS) begin
         last_col = CW'(MAX_GRID_COLS - 1);
      end else begin
         last_col = CW'(grid_cols - 4'd1);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sweep_end = (sweep_ff == SW'(SWEEP_LEN - 1));
   assign scan_end  = (row_ff == last_row) && (col_ff == last_col);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ggoa_pkg::ST_RESET_SWEEP: if (sweep_end) state_in = ggoa_pkg::ST_IDLE;
         ggoa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == ggoa_pkg::FUNC_CLEAR) ? ggoa_pkg::ST_CLEAR_SWEEP
                                                              : ggoa_pkg::ST_COST;
            end
         end
         ggoa_pkg::ST_COST: begin
            if (cnt_ff == 3'(ggoa_pkg::COST_CYCLES - 1)) state_in = ggoa_pkg::ST_SCAN;
         end
         ggoa_pkg::ST_SCAN: if (scan_end) state_in = ggoa_pkg::ST_DRAIN;
         ggoa_pkg::ST_DRAIN: begin
            if (cnt_ff == 3'(ggoa_pkg::DRAIN_CYCLES - 1)) state_in = ggoa_pkg::ST_COMMIT;
         end
         ggoa_pkg::ST_COMMIT: if (out_free) state_in = ggoa_pkg::ST_IDLE;
         ggoa_pkg::ST_CLEAR_SWEEP: if (sweep_end) state_in = ggoa_pkg::ST_CLEAR_DONE;
         ggoa_pkg::ST_CLEAR_DONE: if (out_free) state_in = ggoa_pkg::ST_IDLE;
         default: state_in = ggoa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in   = '0;
      sweep_in = '0;
      row_in   = '0;
      col_in   = '0;
      if ((state_ff == ggoa_pkg::ST_COST || state_ff == ggoa_pkg::ST_DRAIN)
          && state_in == state_ff) begin
         cnt_in = cnt_ff + 3'd1;
      end
      if ((state_ff == ggoa_pkg::ST_RESET_SWEEP || state_ff == ggoa_pkg::ST_CLEAR_SWEEP)
          && !sweep_end) begin
         sweep_in = sweep_ff + SW'(1);
      end
      if (state_ff == ggoa_pkg::ST_SCAN && !scan_end) begin
         if (col_ff == last_col) begin
            row_in = row_ff + RW'(1);
         end else begin
            row_in = row_ff;
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.rows_multi = (last_row != '0);
      req_ready      = 1'b0;
      case (state_ff)
         ggoa_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ggoa_pkg::ST_COST:  cmd.scan_start = 1'b1;
         ggoa_pkg::ST_SCAN:  cmd.scan_valid = 1'b1;
         ggoa_pkg::ST_COMMIT: begin
            cmd.commit = out_free;
            cmd.emit   = out_free;
         end
         ggoa_pkg::ST_RESET_SWEEP, ggoa_pkg::ST_CLEAR_SWEEP: cmd.sweep = 1'b1;
         ggoa_pkg::ST_CLEAR_DONE: begin
            cmd.emit      = out_free;
            cmd.emit_zero = out_free;
         end
         default: cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ggoa_pkg::ST_RESET_SWEEP;
         cnt_ff       <= '0;
         sweep_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sweep_ff     <= sweep_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign scan_row   = row_ff;
   assign scan_col   = col_ff;
   assign sweep_addr = sweep_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result emitted over an untaken result");
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_valid |-> (row_ff <= last_row && col_ff <= last_col))
      else $error("scan index beyond active grid");
   a_commit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ggoa_pkg::ST_COMMIT && $past(state_ff) != ggoa_pkg::ST_COMMIT)
      |-> $past(state_ff) == ggoa_pkg::ST_DRAIN)
      else $error("commit entered without draining the scan pipeline");
   a_capture_next: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ggoa_pkg::ST_COST || state_ff == ggoa_pkg::ST_CLEAR_SWEEP))
      else $error("accepted request did not start work");

endmodule

>>> rtl/ggoa_dpath.sv
`timescale 1ns / 1ps
// Datapath: cost terms, load and owner memories, cell scoring pipeline, best pick.
// Depends on ggoa_pkg; driven by ggoa_ctrl commands.
module ggoa_dpath #(
   parameter int MAX_TASKS     = 1024,
   parameter int MAX_GRID_ROWS = 8,
   parameter int MAX_GRID_COLS = 8,
   localparam int RW        = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1,
   localparam int CW        = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1,
   localparam int CELLS     = MAX_GRID_ROWS * MAX_GRID_COLS,
   localparam int SWEEP_LEN = (MAX_TASKS > CELLS) ? MAX_TASKS : CELLS,
   localparam int SW        = $clog2(SWEEP_LEN)
) (
   input  logic              clock,
   input  logic              reset,
   input  ggoa_pkg::cmd_type cmd,
   input  logic [RW-1:0]     scan_row,
   input  logic [CW-1:0]     scan_col,
   input  logic [SW-1:0]     sweep_addr,
   input  logic [15:0]       weight,
   input  logic [9:0]        req_task_index,
   input  logic [9:0]        req_task_columns,
   input  logic [15:0]       req_panel_height,
   input  logic [10:0]       req_parent_index,
   output logic [2:0]        rsp_chosen_row,
   output logic [2:0]        rsp_chosen_col,
   output logic [61:0]       rsp_max_column_load,
   output logic [61:0]       rsp_max_row_load,
   output logic [61:0]       rsp_max_cell_load
);
   localparam int CLW       = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int TW        = $clog2(MAX_TASKS);
   localparam int ENT_W     = 1 + RW + CW;
   localparam int LW        = ggoa_pkg::LOAD_W;
   localparam int KW        = ggoa_pkg::COST_W;
   localparam int PW        = ggoa_pkg::PEN_W;
   localparam int SCW       = ggoa_pkg::SCORE_W;

   function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] a, input logic [KW-1:0] b);
      logic [LW:0] s;
      s = {1'b0, a} + (LW+1)'(b);
      return (s > {1'b0, ggoa_pkg::LOAD_MAX}) ? ggoa_pkg::LOAD_MAX : s[LW-1:0];
   endfunction

   // request capture
   logic [9:0]  c_ff, task_ff;
   logic [15:0] below_ff, below_in;
   logic [10:0] parent_ff;

   assign below_in = (req_panel_height < {6'd0, req_task_columns}) ? 16'd0
                     : req_panel_height - {6'd0, req_task_columns};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         c_ff      <= req_task_columns;
         task_ff   <= req_task_index;
         below_ff  <= below_in;
         parent_ff <= req_parent_index;
      end
   end

   // cost terms, four register stages
   logic [19:0] cc_ff;
   logic [25:0] bc_ff;
   logic [31:0] bb_ff;
   logic [20:0] w20_ff;
   logic [29:0] ccc_ff;
   logic [35:0] bcc_ff;
   logic [41:0] bbc_ff;
   logic [28:0] comm_ff, comm_in;
   logic [KW-1:0] pa_ff, ra_ff, rb_ff, ca_ff, cb_ff, cd_ff;
   logic [PW-1:0] wpc_ff, wpr_ff;
   logic [KW-1:0] panel_sum, row_sum, cell_sum;
   logic [KW-1:0] panel_ff, row_ff, cell_ff;

   assign comm_in   = cmd.rows_multi ? {bc_ff, 3'b000} : 29'd0;
   assign panel_sum = pa_ff + KW'(comm_ff);
   assign row_sum   = ra_ff + rb_ff;
   assign cell_sum  = ca_ff + cb_ff + cd_ff;

   always_ff @(posedge clock) begin
      cc_ff    <= 20'(c_ff) * 20'(c_ff);
      bc_ff    <= 26'(below_ff) * 26'(c_ff);
      bb_ff    <= 32'(below_ff) * 32'(below_ff);
      w20_ff   <= {1'b0, weight, 4'b0000} + {3'b000, weight, 2'b00};
      ccc_ff   <= 30'(cc_ff) * 30'(c_ff);
      bcc_ff   <= 36'(below_ff) * 36'(cc_ff);
      bbc_ff   <= 42'(bb_ff) * 42'(c_ff);
      comm_ff  <= comm_in;
      pa_ff    <= KW'({bcc_ff, 3'b000}) + KW'({bbc_ff, 2'b00});
      ra_ff    <= KW'({ccc_ff, 3'b000}) + KW'({cc_ff, 3'b000});
      rb_ff    <= KW'({bc_ff, 4'b0000}) + KW'(comm_ff);
      ca_ff    <= KW'({ccc_ff, 3'b000}) + KW'({bcc_ff, 3'b000});
      cb_ff    <= KW'({cc_ff, 3'b000}) + KW'({bc_ff, 4'b0000});
      cd_ff    <= KW'(bbc_ff) + KW'(comm_ff);
      wpc_ff   <= PW'(w20_ff) * PW'(comm_ff);
      wpr_ff   <= PW'(w20_ff) * PW'(comm_ff[28:1]);
      panel_ff <= (panel_sum < ggoa_pkg::COST_FLOOR) ? ggoa_pkg::COST_FLOOR : panel_sum;
      row_ff   <= (row_sum < ggoa_pkg::COST_FLOOR) ? ggoa_pkg::COST_FLOOR : row_sum;
      cell_ff  <= (cell_sum < ggoa_pkg::COST_FLOOR) ? ggoa_pkg::COST_FLOOR : cell_sum;
   end

   // best cell so far
   logic           have_best_ff;
   logic [SCW-1:0] best_score_ff;
   logic [RW-1:0]  best_r_ff;
   logic [CW-1:0]  best_c_ff;
   logic [LW-1:0]  best_p_ff, best_q_ff, best_s_ff;

   // owner table
   logic [ENT_W-1:0] owner_mem [MAX_TASKS];
   logic [ENT_W-1:0] own_rd_ff, own_wd;
   logic [TW-1:0]    own_wa;
   logic             own_we, task_ok, parent_ok, have_parent;
   logic [RW-1:0]    own_row;
   logic [CW-1:0]    own_col;

   assign task_ok   = 32'(task_ff) < MAX_TASKS;
   assign parent_ok = 32'(parent_ff) < MAX_TASKS;
   assign own_row   = own_rd_ff[RW+CW-1:CW];
   assign own_col   = own_rd_ff[CW-1:0];
   assign have_parent = (weight != 16'd0) && parent_ok && own_rd_ff[ENT_W-1];

   always_comb begin
      own_we = 1'b0;
      own_wa = TW'(sweep_addr);
      own_wd = '0;
      if (cmd.sweep) begin
         own_we = 32'(sweep_addr) < MAX_TASKS;
      end else if (cmd.commit) begin
         own_we = task_ok;
         own_wa = TW'(task_ff);
         own_wd = {1'b1, best_r_ff, best_c_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (own_we) owner_mem[own_wa] <= own_wd;
      own_rd_ff <= owner_mem[TW'(parent_ff)];
   end

   // load memories
   logic [LW-1:0] col_mem  [MAX_GRID_COLS];
   logic [LW-1:0] row_mem  [MAX_GRID_ROWS];
   logic [LW-1:0] cell_mem [CELLS];
   logic [LW-1:0] col_rd_ff, row_rd_ff, cell_rd_ff;
   logic [CLW-1:0] scan_cell, best_cell;
   logic [CW-1:0]  col_wa;
   logic [RW-1:0]  row_wa;
   logic [CLW-1:0] cell_wa;
   logic [LW-1:0]  col_wd, row_wd, cell_wd;
   logic           col_we, row_we, cell_we;

   assign scan_cell = CLW'(scan_row) * CLW'(MAX_GRID_COLS) + CLW'(scan_col);
   assign best_cell = CLW'(best_r_ff) * CLW'(MAX_GRID_COLS) + CLW'(best_c_ff);

   always_comb begin
      col_we  = cmd.commit;
      row_we  = cmd.commit;
      cell_we = cmd.commit;
      col_wa  = best_c_ff;
      row_wa  = best_r_ff;
      cell_wa = best_cell;
      col_wd  = best_p_ff;
      row_wd  = best_q_ff;
      cell_wd = best_s_ff;
      if (cmd.sweep) begin
         col_we  = 32'(sweep_addr) < MAX_GRID_COLS;
         row_we  = 32'(sweep_addr) < MAX_GRID_ROWS;
         cell_we = 32'(sweep_addr) < CELLS;
         col_wa  = CW'(sweep_addr);
         row_wa  = RW'(sweep_addr);
         cell_wa = CLW'(sweep_addr);
         col_wd  = '0;
         row_wd  = '0;
         cell_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (col_we) col_mem[col_wa] <= col_wd;
      col_rd_ff <= col_mem[scan_col];
   end

   always_ff @(posedge clock) begin
      if (row_we) row_mem[row_wa] <= row_wd;
      row_rd_ff <= row_mem[scan_row];
   end

   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_wa] <= cell_wd;
      cell_rd_ff <= cell_mem[scan_cell];
   end

   // scoring pipeline
   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic [RW-1:0] r1_ff, r2_ff, r3_ff, r4_ff;
   logic [CW-1:0] c1_ff, c2_ff, c3_ff, c4_ff;
   logic [LW-1:0] p2_ff, q2_ff, s2_ff, p3_ff, q3_ff, s3_ff, p4_ff, q4_ff, s4_ff;
   logic [PW:0]   pen2_in, pen2_ff, pen3_ff;
   logic [LW-1:0] m3_in, m3_ff;
   logic [LW+1:0] sum3_ff;
   logic [SCW-1:0] score4_ff, score4_in;
   logic          take;

   always_comb begin
      pen2_in = '0;
      if (have_parent && c1_ff != own_col) pen2_in = pen2_in + (PW+1)'(wpc_ff);
      if (have_parent && r1_ff != own_row) pen2_in = pen2_in + (PW+1)'(wpr_ff);
      m3_in = (p2_ff > q2_ff) ? p2_ff : q2_ff;
      if (s2_ff > m3_in) m3_in = s2_ff;
   end

   assign score4_in = SCW'({m3_ff, 12'd0}) + SCW'({m3_ff, 10'd0}) + SCW'({sum3_ff, 8'd0})
                      + SCW'(pen3_ff);
   assign take = v4_ff && (!have_best_ff || score4_ff < best_score_ff);

   always_ff @(posedge clock) begin
      r1_ff     <= scan_row;
      c1_ff     <= scan_col;
      r2_ff     <= r1_ff;
      c2_ff     <= c1_ff;
      p2_ff     <= sat_add(col_rd_ff, panel_ff);
      q2_ff     <= sat_add(row_rd_ff, row_ff);
      s2_ff     <= sat_add(cell_rd_ff, cell_ff);
      pen2_ff   <= pen2_in;
      r3_ff     <= r2_ff;
      c3_ff     <= c2_ff;
      p3_ff     <= p2_ff;
      q3_ff     <= q2_ff;
      s3_ff     <= s2_ff;
      m3_ff     <= m3_in;
      sum3_ff   <= (LW+2)'(p2_ff) + (LW+2)'(q2_ff) + (LW+2)'(s2_ff);
      pen3_ff   <= pen2_ff;
      r4_ff     <= r3_ff;
      c4_ff     <= c3_ff;
      p4_ff     <= p3_ff;
      q4_ff     <= q3_ff;
      s4_ff     <= s3_ff;
      score4_ff <= score4_in;
      if (take) begin
         best_score_ff <= score4_ff;
         best_r_ff     <= r4_ff;
         best_c_ff     <= c4_ff;
         best_p_ff     <= p4_ff;
         best_q_ff     <= q4_ff;
         best_s_ff     <= s4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         have_best_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.scan_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         have_best_ff <= cmd.scan_start ? 1'b0 : (have_best_ff || take);
      end
   end

   // running maxima and result register
   logic [LW-1:0] mx_col_ff, mx_row_ff, mx_cell_ff;
   logic [LW-1:0] mx_col_in, mx_row_in, mx_cell_in;
   logic [2:0]    out_row_ff, out_col_ff;
   logic [LW-1:0] out_mc_ff, out_mr_ff, out_ml_ff;

   assign mx_col_in  = (best_p_ff > mx_col_ff) ? best_p_ff : mx_col_ff;
   assign mx_row_in  = (best_q_ff > mx_row_ff) ? best_q_ff : mx_row_ff;
   assign mx_cell_in = (best_s_ff > mx_cell_ff) ? best_s_ff : mx_cell_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep) begin
         mx_col_ff  <= '0;
         mx_row_ff  <= '0;
         mx_cell_ff <= '0;
      end else if (cmd.commit) begin
         mx_col_ff  <= mx_col_in;
         mx_row_ff  <= mx_row_in;
         mx_cell_ff <= mx_cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (cmd.emit_zero) begin
            out_row_ff <= '0;
            out_col_ff <= '0;
            out_mc_ff  <= '0;
            out_mr_ff  <= '0;
            out_ml_ff  <= '0;
         end else begin
            out_row_ff <= 3'(best_r_ff);
            out_col_ff <= 3'(best_c_ff);
            out_mc_ff  <= mx_col_in;
            out_mr_ff  <= mx_row_in;
            out_ml_ff  <= mx_cell_in;
         end
      end
   end

   assign rsp_chosen_row      = out_row_ff;
   assign rsp_chosen_col      = out_col_ff;
   assign rsp_max_column_load = out_mc_ff;
   assign rsp_max_row_load    = out_mr_ff;
   assign rsp_max_cell_load   = out_ml_ff;

endmodule

>>> rtl/greedy_grid_owner_assigner.sv
`timescale 1ns / 1ps
// Greedy grid owner assigner, top level.
// Depends on ggoa_pkg, ggoa_if, ggoa_ctrl and ggoa_dpath.
//
// Usage:
//   req_if carries one request: func 0 clears loads, placed flags and maxima;
//   func 1 places one task on the lowest scoring cell of the active grid.
//   rsp_if returns one result per request: chosen cell and running maxima.
//   The APB port holds grid_rows (0x0), grid_cols (0x4), affinity_weight (0x8);
//   write only while no request is in flight.
// Sequence:
//   A placement runs the cost multiplies, then scores one cell of the active grid
//   per cycle through the load memory reads, drains the scoring pipeline and
//   commits. A clear sweeps max(MAX_TASKS, MAX_GRID_ROWS*MAX_GRID_COLS)
//   memory addresses, one entry per cycle, then returns its result. One
//   request is in work at a time.
// Reset:
//   After reset the same clearing sweep runs before the first request is taken.
// Stalls:
//   The result register holds until rsp_if.ready; the next request may be
//   accepted meanwhile and its result waits in commit until the register frees.
module greedy_grid_owner_assigner #(
   parameter int MAX_TASKS     = 1024,
   parameter int MAX_GRID_ROWS = 8,
   parameter int MAX_GRID_COLS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   ggoa_req_if.sink                            req_if,
   ggoa_rsp_if.source                          rsp_if,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ggoa_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ggoa_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ggoa_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   localparam int RW        = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
   localparam int CW        = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
   localparam int CELLS     = MAX_GRID_ROWS * MAX_GRID_COLS;
   localparam int SWEEP_LEN = (MAX_TASKS > CELLS) ? MAX_TASKS : CELLS;
   localparam int SW        = $clog2(SWEEP_LEN);

   logic [3:0]  grid_rows_ff, grid_cols_ff;
   logic [15:0] weight_ff;
   logic        csr_write;

   ggoa_pkg::cmd_type cmd;
   logic [RW-1:0] scan_row;
   logic [CW-1:0] scan_col;
   logic [SW-1:0] sweep_addr;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= 4'd1;
         grid_cols_ff <= 4'd1;
         weight_ff    <= 16'd0;
      end else if (csr_write) begin
         case (paddr[3:2])
            ggoa_pkg::REG_GRID_ROWS:       grid_rows_ff <= pwdata[3:0];
            ggoa_pkg::REG_GRID_COLS:       grid_cols_ff <= pwdata[3:0];
            ggoa_pkg::REG_AFFINITY_WEIGHT: weight_ff    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         ggoa_pkg::REG_GRID_ROWS:       prdata = {28'd0, grid_rows_ff};
         ggoa_pkg::REG_GRID_COLS:       prdata = {28'd0, grid_cols_ff};
         ggoa_pkg::REG_AFFINITY_WEIGHT: prdata = {16'd0, weight_ff};
         default:                       prdata = '0;
      endcase
   end

   ggoa_ctrl #(
      .MAX_TASKS     (MAX_TASKS),
      .MAX_GRID_ROWS (MAX_GRID_ROWS),
      .MAX_GRID_COLS (MAX_GRID_COLS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_func   (req_if.func),
      .req_ready  (req_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .grid_rows  (grid_rows_ff),
      .grid_cols  (grid_cols_ff),
      .cmd        (cmd),
      .scan_row   (scan_row),
      .scan_col   (scan_col),
      .sweep_addr (sweep_addr)
   );

   ggoa_dpath #(
      .MAX_TASKS     (MAX_TASKS),
      .MAX_GRID_ROWS (MAX_GRID_ROWS),
      .MAX_GRID_COLS (MAX_GRID_COLS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .scan_row            (scan_row),
      .scan_col            (scan_col),
      .sweep_addr          (sweep_addr),
      .weight              (weight_ff),
      .req_task_index      (req_if.task_index),
      .req_task_columns    (req_if.task_columns),
      .req_panel_height    (req_if.panel_height),
      .req_parent_index    (req_if.parent_index),
      .rsp_chosen_row      (rsp_if.chosen_row),
      .rsp_chosen_col      (rsp_if.chosen_col),
      .rsp_max_column_load (rsp_if.max_column_load),
      .rsp_max_row_load    (rsp_if.max_row_load),
      .rsp_max_cell_load   (rsp_if.max_cell_load)
   );

endmodule
